// ===== rtl/sav_pkg.sv =====
package sav_pkg;

  localparam int CH_W      = 4;
  localparam int ANGLE_W   = 12;
  localparam int TICK_W    = 12;
  localparam int DUR_W     = 16;
  localparam int STEP_W    = 13;
  localparam int CFG_IDX_W = 3;

  // Shared serial divider: widest dividend is |diff| * index (12 x 13 bits),
  // widest divisor is the step count (13 bits).
  localparam int DVD_W = 25;
  localparam int DVS_W = 13;

  localparam int DEFAULT_CHANNELS = 16;

  localparam logic [ANGLE_W-1:0] HOME_ANGLE  = 12'd1440;
  localparam logic [ANGLE_W-1:0] FULL_ANGLE  = 12'd2880;
  localparam logic [DVS_W-1:0]   MS_PER_STEP = 13'd10;

  localparam logic [CH_W-1:0] CH_GROUP_A = 4'd3;
  localparam logic [CH_W-1:0] CH_GROUP_B = 4'd4;

  localparam logic [TICK_W-1:0] RST_DEF_MIN = 12'd115;
  localparam logic [TICK_W-1:0] RST_DEF_MAX = 12'd490;
  localparam logic [TICK_W-1:0] RST_CHA_MIN = 12'd150;
  localparam logic [TICK_W-1:0] RST_CHA_MAX = 12'd560;
  localparam logic [TICK_W-1:0] RST_CHB_MIN = 12'd150;
  localparam logic [TICK_W-1:0] RST_CHB_MAX = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEF_MIN = 3'd0,
    REG_DEF_MAX = 3'd1,
    REG_CHA_MIN = 3'd2,
    REG_CHA_MAX = 3'd3,
    REG_CHB_MIN = 3'd4,
    REG_CHB_MAX = 3'd5
  } reg_idx_t;

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic {
    ST_STEP = 1'b0,
    ST_BUSY = 1'b1
  } status_t;

endpackage

// ===== rtl/servo_angle_ramp_to_pwm_core.sv =====
// Servo ramp generator: turns move and tick requests into PWM pulse-end ticks.
// Input channel (in_valid/in_ready): a move request starts a linear ramp from
// the channel's stored angle to the target; a tick request advances the ramp
// by one step. A move while a ramp runs yields one result with busy status.
// A tick while no ramp runs yields no result.
// Output channel (out_valid/out_ready): one result per move and per tick that
// advances a ramp. A finished result sits in the output register; a new request
// is taken while it waits, and processing stalls only when the next result is
// ready and the output register is still full.
// Work: every division goes through one bit-serial divider, which is loaded
// before it starts and whose quotient is taken when it is done. A tick needs
// two divisions, an accepted move three (step count, offset, tick mapping) and
// a rejected move none.
// One request is in work at a time; the next is taken in the cycle after the
// result is registered.
// Configuration (cfg_we/cfg_index/cfg_wdata) sets the min/max tick pairs.
// Reset restores the default tick pairs, ends any ramp and sets every channel's
// stored angle to 90 degrees.
module servo_angle_ramp_to_pwm_core #(
  parameter int CHANNELS = sav_pkg::DEFAULT_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [sav_pkg::CH_W-1:0]      in_channel,
  input  logic [sav_pkg::ANGLE_W-1:0]   in_target_angle,
  input  logic [sav_pkg::DUR_W-1:0]     in_duration_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [sav_pkg::CH_W-1:0]      out_servo_channel,
  output logic [sav_pkg::TICK_W-1:0]    out_pulse_end_tick,
  output logic                          out_final_step,
  input  logic                          cfg_we,
  input  logic [sav_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sav_pkg::TICK_W-1:0]    cfg_wdata
);
  import sav_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NUM_CH_CODES = 2 ** CH_W;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_STEPS = 8'b0000_0100,
    S_MUL1  = 8'b0000_1000,
    S_DIV1  = 8'b0001_0000,
    S_MUL2  = 8'b0010_0000,
    S_DIV2  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r;

  // Tick pair registers.
  logic [TICK_W-1:0] def_min_r, def_max_r, cha_min_r, cha_max_r, chb_min_r, chb_max_r;

  // Ramp state.
  logic               active_r;
  logic [CH_W-1:0]    ch_r;
  logic [AW-1:0]      cidx_r;
  logic [ANGLE_W-1:0] tgt_r;
  logic [ANGLE_W-1:0] start_r;
  logic               diff_neg_r;
  logic [ANGLE_W-1:0] absdiff_r;
  logic [STEP_W-1:0]  steps_r;
  logic [STEP_W-1:0]  index_r;
  logic [ANGLE_W-1:0] pos_r;
  logic               dneg_r;

  // Pending result and output register.
  logic               res_status_r;
  logic [CH_W-1:0]    res_ch_r;
  logic [TICK_W-1:0]  res_tick_r;
  logic               res_last_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [TICK_W-1:0]  out_tick_r;
  logic               out_last_r;

  // Divider operands.
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic             div_start_r;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DVS_W-1:0] div_rem;

  logic [AW-1:0] ch_mod [NUM_CH_CODES];

  logic               in_acc;
  logic               mem_rd_en;
  logic               mem_wr_en;
  logic [ANGLE_W-1:0] mem_rd_data;
  logic               emit_go;

  logic [TICK_W-1:0]  sel_lo, sel_hi;
  logic [ANGLE_W:0]   start_diff;
  logic [ANGLE_W:0]   delta;
  logic [STEP_W-1:0]  idx_inc;
  logic [ANGLE_W-1:0] off_q;
  logic [ANGLE_W-1:0] pos_raw;
  logic [TICK_W-1:0]  qm;
  logic [TICK_W:0]    qadj;
  logic [TICK_W-1:0]  tick_v;

  // Channel-to-entry map, evaluated at elaboration.
  for (genvar g = 0; g < NUM_CH_CODES; g++) begin : g_chmod
    assign ch_mod[g] = AW'(g % CHANNELS);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mem_rd_en = in_acc && (in_opcode == OP_MOVE) && !active_r;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign mem_wr_en = emit_go && (res_status_r == ST_STEP) && res_last_r;

  sav_angle_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (ch_mod[in_channel]),
    .wr_en   (mem_wr_en),
    .wr_addr (cidx_r),
    .wr_data (tgt_r),
    .rd_data (mem_rd_data)
  );

  sav_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    if (ch_r == CH_GROUP_A) begin
      sel_lo = cha_min_r;
      sel_hi = cha_max_r;
    end else if (ch_r == CH_GROUP_B) begin
      sel_lo = chb_min_r;
      sel_hi = chb_max_r;
    end else begin
      sel_lo = def_min_r;
      sel_hi = def_max_r;
    end
  end

  always_comb begin
    start_diff = {1'b0, tgt_r} - {1'b0, mem_rd_data};
    delta      = {1'b0, sel_hi} - {1'b0, sel_lo};
    idx_inc    = index_r + 1'b1;
    // The offset never exceeds |diff|, so the position stays within 0..4095.
    off_q      = div_quot[ANGLE_W-1:0];
    pos_raw    = diff_neg_r ? (start_r - off_q) : (start_r + off_q);
    // Floor division for a falling slope: round the magnitude up.
    qm         = div_quot[TICK_W-1:0];
    qadj       = {1'b0, qm} + {{TICK_W{1'b0}}, (dneg_r && (div_rem != '0))};
    tick_v     = dneg_r ? (sel_lo - qadj[TICK_W-1:0]) : (sel_lo + qm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_min_r <= RST_DEF_MIN;
      def_max_r <= RST_DEF_MAX;
      cha_min_r <= RST_CHA_MIN;
      cha_max_r <= RST_CHA_MAX;
      chb_min_r <= RST_CHB_MIN;
      chb_max_r <= RST_CHB_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEF_MIN: def_min_r <= cfg_wdata;
        REG_DEF_MAX: def_max_r <= cfg_wdata;
        REG_CHA_MIN: cha_min_r <= cfg_wdata;
        REG_CHA_MAX: cha_max_r <= cfg_wdata;
        REG_CHB_MIN: chb_min_r <= cfg_wdata;
        REG_CHB_MAX: chb_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_opcode == OP_TICK) begin
              if (active_r) begin
                state_r <= S_MUL1;
              end
            end else if (active_r) begin
              res_status_r <= ST_BUSY;
              res_ch_r     <= in_channel;
              res_tick_r   <= '0;
              res_last_r   <= 1'b0;
              state_r      <= S_EMIT;
            end else begin
              ch_r        <= in_channel;
              cidx_r      <= ch_mod[in_channel];
              tgt_r       <= in_target_angle;
              dvd_r       <= DVD_W'(in_duration_ms);
              dvs_r       <= MS_PER_STEP;
              div_start_r <= 1'b1;
              state_r     <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          start_r    <= mem_rd_data;
          diff_neg_r <= start_diff[ANGLE_W];
          absdiff_r  <= start_diff[ANGLE_W] ? ANGLE_W'(-start_diff)
                                            : start_diff[ANGLE_W-1:0];
          state_r    <= S_STEPS;
        end
        S_STEPS: begin
          if (div_done) begin
            steps_r  <= (div_quot == '0) ? STEP_W'(1) : div_quot[STEP_W-1:0];
            index_r  <= '0;
            active_r <= 1'b1;
            state_r  <= S_MUL1;
          end
        end
        S_MUL1: begin
          index_r     <= idx_inc;
          dvd_r       <= {{(DVD_W-ANGLE_W){1'b0}}, absdiff_r}
                       * {{(DVD_W-STEP_W){1'b0}}, idx_inc};
          dvs_r       <= steps_r;
          div_start_r <= 1'b1;
          state_r     <= S_DIV1;
        end
        S_DIV1: begin
          if (div_done) begin
            pos_r   <= (pos_raw > FULL_ANGLE) ? FULL_ANGLE : pos_raw;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          dneg_r      <= delta[TICK_W];
          dvd_r       <= {{(DVD_W-ANGLE_W){1'b0}}, pos_r}
                       * {{(DVD_W-TICK_W){1'b0}},
                          (delta[TICK_W] ? TICK_W'(-delta) : delta[TICK_W-1:0])};
          dvs_r       <= DVS_W'(FULL_ANGLE);
          div_start_r <= 1'b1;
          state_r     <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            res_status_r <= ST_STEP;
            res_ch_r     <= ch_r;
            res_tick_r   <= tick_v;
            res_last_r   <= (index_r >= steps_r);
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (mem_wr_en) begin
              active_r <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status_r <= res_status_r;
      out_ch_r     <= res_ch_r;
      out_tick_r   <= res_tick_r;
      out_last_r   <= res_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_servo_channel  = out_ch_r;
  assign out_pulse_end_tick = out_tick_r;
  assign out_final_step     = out_last_r;

endmodule

// ===== rtl/sav_div.sv =====
module sav_div #(
  parameter int DVD_W = sav_pkg::DVD_W,
  parameter int DVS_W = sav_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);
  import sav_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W:0]   diff_w;

  // One quotient bit per cycle, restoring form. The partial remainder always
  // stays below the divisor, so it fits in DVS_W bits.
  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    diff_w  = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
    rem_nxt = ge ? diff_w[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/sav_angle_mem.sv =====
module sav_angle_mem #(
  parameter int DEPTH = sav_pkg::DEFAULT_CHANNELS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sav_pkg::ANGLE_W-1:0] wr_data,
  output logic [sav_pkg::ANGLE_W-1:0] rd_data
);
  import sav_pkg::*;

  logic [ANGLE_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic [ANGLE_W-1:0] rd_data_r;
  logic               rd_hit_r;

  // An entry never written since reset reads as the home angle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : HOME_ANGLE;

endmodule
